[design/tcp_pkg.sv]
`timescale 1ns / 1ps

package tcp_pkg;

   // Default sizing, handed to the top level as parameter defaults.
   localparam int POS_WIDTH_DEF    = 20;
   localparam int CORDIC_STEPS_DEF = 16;

   // Field widths of the channels.
   localparam int ACTION_W    = 3;
   localparam int OPERAND_W   = 17;
   localparam int COORD_W     = 16;
   localparam int ORIGIN_W    = 12;
   localparam int HEIGHT_W    = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int HEADING_W   = 16;

   // Register values after reset.
   localparam int RESET_ORIGIN_X = 400;
   localparam int RESET_ORIGIN_Y = 300;
   localparam int RESET_HEIGHT   = 600;

   // Angles in 1/128 degree.
   localparam int FULL_TURN    = 46080;
   localparam int HALF_TURN    = 23040;
   localparam int QUARTER_TURN = 11520;

   // CORDIC datapath: 16 extra fractional bits on the vector, angle in 1/65536 degree.
   localparam int INV_GAIN_Q30   = 652032874;
   localparam int GAIN_W         = 30;
   localparam int PRESCALE_SHIFT = 14;
   localparam int PRESCALE_ROUND = 8192;
   localparam int FRAC_SHIFT     = 16;
   localparam int ANGLE_SHIFT    = 9;
   localparam int CORDIC_W       = 36;
   localparam int ANGLE_W        = 26;
   localparam int DELTA_W        = CORDIC_W - FRAC_SHIFT;
   localparam int ATAN_COUNT     = 24;
   localparam int ATAN_IDX_W     = 5;
   localparam int ATAN_W         = 22;

   typedef enum logic [ACTION_W-1:0] {
      ACT_HOME      = 3'd0,
      ACT_FORWARD   = 3'd1,
      ACT_LEFT      = 3'd2,
      ACT_RIGHT     = 3'd3,
      ACT_PEN_UP    = 3'd4,
      ACT_PEN_DOWN  = 3'd5
   } action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ORIGIN_X = 2'd0,
      CSR_ORIGIN_Y = 2'd1,
      CSR_HEIGHT   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WRAP,
      ST_ROTATE,
      ST_LATCH
   } tcp_state_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_RUN,
      CS_ROUND
   } cordic_state_type;

   typedef struct packed {
      logic                        start;
      logic [HEADING_W-1:0]        heading;
      logic signed [OPERAND_W-1:0] distance;
   } cordic_req_type;

   typedef struct packed {
      logic                      busy;
      logic                      done;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
   } cordic_rsp_type;

   // Arctangent of 2^-i in 1/65536 degree, rounded.
   function automatic logic [ATAN_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic [ATAN_W-1:0] value;
      unique case (idx)
         5'd0:    value = 22'd2949120;
         5'd1:    value = 22'd1740967;
         5'd2:    value = 22'd919879;
         5'd3:    value = 22'd466945;
         5'd4:    value = 22'd234379;
         5'd5:    value = 22'd117304;
         5'd6:    value = 22'd58666;
         5'd7:    value = 22'd29335;
         5'd8:    value = 22'd14668;
         5'd9:    value = 22'd7334;
         5'd10:   value = 22'd3667;
         5'd11:   value = 22'd1833;
         5'd12:   value = 22'd917;
         5'd13:   value = 22'd458;
         5'd14:   value = 22'd229;
         5'd15:   value = 22'd115;
         5'd16:   value = 22'd57;
         5'd17:   value = 22'd29;
         5'd18:   value = 22'd14;
         5'd19:   value = 22'd7;
         5'd20:   value = 22'd4;
         5'd21:   value = 22'd2;
         5'd22:   value = 22'd1;
         default: value = 22'd0;
      endcase
      return value;
   endfunction

endpackage

[design/tcp_req_if.sv]
`timescale 1ns / 1ps

// Command channel: one action with its operand per transaction.
interface tcp_req_if import tcp_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [ACTION_W-1:0]         action;
   logic signed [OPERAND_W-1:0] operand;

   modport source (output valid, action, operand, input ready);
   modport sink   (input valid, action, operand, output ready);
endinterface

[design/tcp_rsp_if.sv]
`timescale 1ns / 1ps

// Segment channel: one line segment in screen coordinates per transaction.
interface tcp_rsp_if import tcp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] x_start;
   logic signed [COORD_W-1:0] y_start;
   logic signed [COORD_W-1:0] x_end;
   logic signed [COORD_W-1:0] y_end;

   modport source (output valid, x_start, y_start, x_end, y_end, input ready);
   modport sink   (input valid, x_start, y_start, x_end, y_end, output ready);
endinterface

[design/tcp_csr_if.sv]
`timescale 1ns / 1ps

// Register write channel: index and data per transaction.
interface tcp_csr_if import tcp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[design/tcp_cordic.sv]
`timescale 1ns / 1ps

module tcp_cordic import tcp_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  cordic_req_type req_in,
   output cordic_rsp_type rsp_out
);

   localparam int STEPS  = (CORDIC_STEPS > ATAN_COUNT) ? ATAN_COUNT : CORDIC_STEPS;
   localparam int ITER_W = $clog2(STEPS);
   localparam int PROD_W = OPERAND_W + GAIN_W;
   localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(STEPS - 1);

   localparam logic signed [HEADING_W:0] FULL_S    = (HEADING_W + 1)'(FULL_TURN);
   localparam logic signed [HEADING_W:0] HALF_S    = (HEADING_W + 1)'(HALF_TURN);
   localparam logic signed [HEADING_W:0] QUARTER_S = (HEADING_W + 1)'(QUARTER_TURN);
   localparam logic signed [HEADING_W:0] NQUARTER_S = -(HEADING_W + 1)'(QUARTER_TURN);
   localparam logic [PROD_W-1:0] GAIN_EXT   = PROD_W'(INV_GAIN_Q30);
   localparam logic [PROD_W-1:0] PRE_ROUND  = PROD_W'(PRESCALE_ROUND);
   localparam logic signed [CORDIC_W-1:0] HALF_LSB = CORDIC_W'(1 << (FRAC_SHIFT - 1));

   cordic_state_type state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic done_ff, done_in;
   logic flip_ff, flip_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ANGLE_W-1:0]  z_ff, z_in;
   logic signed [DELTA_W-1:0]  dx_ff, dx_in, dy_ff, dy_in;

   logic signed [HEADING_W:0]  h_wrap, h_fold;
   logic                       fold;
   logic [OPERAND_W-1:0]       mag;
   logic [PROD_W-1:0]          product, scaled;
   logic signed [CORDIC_W-1:0] x_load, xs, ys, x_fin, y_fin, x_rnd, y_rnd;
   logic signed [ANGLE_W-1:0]  z_load, atan_z;

   // Start of a rotation: fold the heading into +/-90 degrees and prescale the distance.
   always_comb begin
      h_wrap = {1'b0, req_in.heading};
      if (h_wrap >= HALF_S) begin
         h_wrap = h_wrap - FULL_S;
      end
      fold   = 1'b0;
      h_fold = h_wrap;
      if (h_wrap > QUARTER_S) begin
         h_fold = h_wrap - HALF_S;
         fold   = 1'b1;
      end else if (h_wrap < NQUARTER_S) begin
         h_fold = h_wrap + HALF_S;
         fold   = 1'b1;
      end
      mag     = req_in.distance[OPERAND_W-1] ? OPERAND_W'(-req_in.distance)
                                             : OPERAND_W'(req_in.distance);
      product = PROD_W'(mag) * GAIN_EXT;
      scaled  = (product + PRE_ROUND) >> PRESCALE_SHIFT;
      x_load  = signed'(CORDIC_W'(scaled));
      z_load  = ANGLE_W'(h_fold) <<< ANGLE_SHIFT;
   end

   // One micro-rotation of the shared datapath, and the final sign and rounding.
   always_comb begin
      xs     = x_ff >>> iter_ff;
      ys     = y_ff >>> iter_ff;
      atan_z = signed'({{(ANGLE_W - ATAN_W){1'b0}}, atan_entry(ATAN_IDX_W'(iter_ff))});
      x_fin  = flip_ff ? -x_ff : x_ff;
      y_fin  = flip_ff ? -y_ff : y_ff;
      x_rnd  = x_fin + HALF_LSB;
      y_rnd  = y_fin + HALF_LSB;
   end

   // Sequencer: load, iterate over the steps, then round.
   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      done_in  = 1'b0;
      flip_in  = flip_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_in.start) begin
               x_in     = x_load;
               y_in     = '0;
               z_in     = z_load;
               flip_in  = fold ^ req_in.distance[OPERAND_W-1];
               iter_in  = '0;
               state_in = CS_RUN;
            end
         end
         CS_RUN: begin
            if (!z_ff[ANGLE_W-1]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_z;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_z;
            end
            if (iter_ff == LAST_ITER) begin
               state_in = CS_ROUND;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end
         CS_ROUND: begin
            dx_in    = x_rnd[CORDIC_W-1:FRAC_SHIFT];
            dy_in    = y_rnd[CORDIC_W-1:FRAC_SHIFT];
            done_in  = 1'b1;
            state_in = CS_IDLE;
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      flip_ff <= flip_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
   end

   assign rsp_out.busy = (state_ff != CS_IDLE);
   assign rsp_out.done = done_ff;
   assign rsp_out.dx   = dx_ff;
   assign rsp_out.dy   = dy_ff;

endmodule

[design/tcp_screen.sv]
`timescale 1ns / 1ps

module tcp_screen import tcp_pkg::*; #(
   parameter int POS_WIDTH = POS_WIDTH_DEF
) (
   input  logic signed [POS_WIDTH-1:0] pos_x,
   input  logic signed [POS_WIDTH-1:0] pos_y,
   input  logic [ORIGIN_W-1:0]         col_base,
   input  logic [ORIGIN_W-1:0]         row_base,
   input  logic [HEIGHT_W-1:0]         height,
   output logic signed [COORD_W-1:0]   screen_x,
   output logic signed [COORD_W-1:0]   screen_y
);

   localparam int SCR_W = ((POS_WIDTH > 18) ? POS_WIDTH : 18) + 3;
   localparam int PIX_W = SCR_W - 4;
   localparam logic signed [PIX_W-1:0] PIX_MAX = PIX_W'(32767);
   localparam logic signed [PIX_W-1:0] PIX_MIN = PIX_W'(-32768);

   logic signed [SCR_W-1:0] cx, cy;

   // Truncate toward zero to whole pixels, then saturate to the coordinate range.
   function automatic logic signed [COORD_W-1:0] to_pixel(input logic signed [SCR_W-1:0] v);
      logic signed [SCR_W-1:0] biased;
      logic signed [PIX_W-1:0] q;
      biased = v + (v[SCR_W-1] ? SCR_W'(15) : SCR_W'(0));
      q      = biased[SCR_W-1:4];
      if (q > PIX_MAX) begin
         return PIX_MAX[COORD_W-1:0];
      end else if (q < PIX_MIN) begin
         return PIX_MIN[COORD_W-1:0];
      end
      return q[COORD_W-1:0];
   endfunction

   // Shift by the origin and flip the y axis downward.
   always_comb begin
      cx = SCR_W'(pos_x) + signed'(SCR_W'({col_base, 4'b0000}));
      cy = signed'(SCR_W'({height, 4'b0000})) - SCR_W'(pos_y)
           - signed'(SCR_W'({row_base, 4'b0000}));
      screen_x = to_pixel(cx);
      screen_y = to_pixel(cy);
   end

endmodule

[design/turtle_command_processor_unit.sv]
// Home, pen and unused commands finish in the idle state; a turn also passes the wrap state.
// Forward waits in the rotate state on the iterative CORDIC rotator, which does one
// micro-rotation per cycle, and with the pen down then latches the segment; a segment
// still held for the sink can stall the latch. The segment is presented once the rotation
// has finished and the output register is free.
// Synchronous active-high reset: turtle home, pen down, screen registers 400/300/600.
`timescale 1ns / 1ps

module turtle_command_processor_unit import tcp_pkg::*; #(
   parameter int POS_WIDTH    = POS_WIDTH_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input logic        clock,
   input logic        reset,
   tcp_req_if.sink    req_chan,
   tcp_rsp_if.source  rsp_chan,
   tcp_csr_if.sink    csr_chan
);

   localparam int SUM_W  = ((POS_WIDTH > DELTA_W) ? POS_WIDTH : DELTA_W) + 1;
   localparam int TURN_W = OPERAND_W + 1;
   localparam longint POS_HI_L = (longint'(1) <<< (POS_WIDTH - 1)) - 1;
   localparam logic signed [SUM_W-1:0]  POS_HI  = SUM_W'(POS_HI_L);
   localparam logic signed [SUM_W-1:0]  POS_LO  = SUM_W'(-POS_HI_L - 1);
   localparam logic signed [TURN_W-1:0] FULL_T  = TURN_W'(FULL_TURN);

   tcp_state_type state_ff, state_in;
   logic signed [POS_WIDTH-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [HEADING_W-1:0]        heading_ff, heading_in;
   logic                        pen_ff, pen_in;
   logic signed [TURN_W-1:0]    turn_acc_ff, turn_acc_in;
   logic [ORIGIN_W-1:0]         col_base_ff, col_base_in, row_base_ff, row_base_in;
   logic [HEIGHT_W-1:0]         height_ff, height_in;
   logic signed [COORD_W-1:0]   start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0]   out_xs_ff, out_xs_in, out_ys_ff, out_ys_in;
   logic signed [COORD_W-1:0]   out_xe_ff, out_xe_in, out_ye_ff, out_ye_in;

   logic                      req_take;
   logic signed [SUM_W-1:0]   sum_x, sum_y;
   logic signed [TURN_W-1:0]  turn_sum;
   logic signed [COORD_W-1:0] scr_x, scr_y;
   cordic_req_type            cordic_req;
   cordic_rsp_type            cordic_rsp;

   tcp_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .req_in  (cordic_req),
      .rsp_out (cordic_rsp)
   );

   // Screen point of the current position.
   tcp_screen #(
      .POS_WIDTH (POS_WIDTH)
   ) u_screen (
      .pos_x    (pos_x_ff),
      .pos_y    (pos_y_ff),
      .col_base (col_base_ff),
      .row_base (row_base_ff),
      .height   (height_ff),
      .screen_x (scr_x),
      .screen_y (scr_y)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;

   assign cordic_req.start    = req_take && (req_chan.action == ACT_FORWARD);
   assign cordic_req.heading  = heading_ff;
   assign cordic_req.distance = req_chan.operand;

   // Position sums for the move and the raw heading sum for a turn.
   always_comb begin
      sum_x = SUM_W'(pos_x_ff) + SUM_W'(cordic_rsp.dx);
      sum_y = SUM_W'(pos_y_ff) + SUM_W'(cordic_rsp.dy);
      if (req_chan.action == ACT_LEFT) begin
         turn_sum = signed'(TURN_W'(heading_ff)) + TURN_W'(req_chan.operand);
      end else begin
         turn_sum = signed'(TURN_W'(heading_ff)) - TURN_W'(req_chan.operand);
      end
   end

   // Register writes; the port never stalls.
   assign csr_chan.ready = 1'b1;

   always_comb begin
      col_base_in = col_base_ff;
      row_base_in = row_base_ff;
      height_in   = height_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_ORIGIN_X: col_base_in = csr_chan.data[ORIGIN_W-1:0];
            CSR_ORIGIN_Y: row_base_in = csr_chan.data[ORIGIN_W-1:0];
            CSR_HEIGHT:   height_in   = csr_chan.data[HEIGHT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Command sequencer.
   always_comb begin
      state_in     = state_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      heading_in   = heading_ff;
      pen_in       = pen_ff;
      turn_acc_in  = turn_acc_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      out_xs_in    = out_xs_ff;
      out_ys_in    = out_ys_ff;
      out_xe_in    = out_xe_ff;
      out_ye_in    = out_ye_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_chan.action)
                  ACT_HOME: begin
                     pos_x_in   = '0;
                     pos_y_in   = '0;
                     heading_in = '0;
                  end
                  ACT_FORWARD: begin
                     start_x_in = scr_x;
                     start_y_in = scr_y;
                     state_in   = ST_ROTATE;
                  end
                  ACT_LEFT, ACT_RIGHT: begin
                     turn_acc_in = turn_sum;
                     state_in    = ST_WRAP;
                  end
                  ACT_PEN_UP:   pen_in = 1'b0;
                  ACT_PEN_DOWN: pen_in = 1'b1;
                  default: begin
                  end
               endcase
            end
         end
         ST_WRAP: begin
            // Bring the heading into one full turn, one correction per cycle.
            if (turn_acc_ff[TURN_W-1]) begin
               turn_acc_in = turn_acc_ff + FULL_T;
            end else if (turn_acc_ff >= FULL_T) begin
               turn_acc_in = turn_acc_ff - FULL_T;
            end else begin
               heading_in = turn_acc_ff[HEADING_W-1:0];
               state_in   = ST_IDLE;
            end
         end
         ST_ROTATE: begin
            if (cordic_rsp.done) begin
               if (sum_x > POS_HI) begin
                  pos_x_in = POS_HI[POS_WIDTH-1:0];
               end else if (sum_x < POS_LO) begin
                  pos_x_in = POS_LO[POS_WIDTH-1:0];
               end else begin
                  pos_x_in = sum_x[POS_WIDTH-1:0];
               end
               if (sum_y > POS_HI) begin
                  pos_y_in = POS_HI[POS_WIDTH-1:0];
               end else if (sum_y < POS_LO) begin
                  pos_y_in = POS_LO[POS_WIDTH-1:0];
               end else begin
                  pos_y_in = sum_y[POS_WIDTH-1:0];
               end
               state_in = pen_ff ? ST_LATCH : ST_IDLE;
            end
         end
         ST_LATCH: begin
            // Wait for the output register to be free, then present the segment.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_xs_in    = start_x_ff;
               out_ys_in    = start_y_ff;
               out_xe_in    = scr_x;
               out_ye_in    = scr_y;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         heading_ff   <= '0;
         pen_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
         col_base_ff  <= ORIGIN_W'(RESET_ORIGIN_X);
         row_base_ff  <= ORIGIN_W'(RESET_ORIGIN_Y);
         height_ff    <= HEIGHT_W'(RESET_HEIGHT);
      end else begin
         state_ff     <= state_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         heading_ff   <= heading_in;
         pen_ff       <= pen_in;
         rsp_valid_ff <= rsp_valid_in;
         col_base_ff  <= col_base_in;
         row_base_ff  <= row_base_in;
         height_ff    <= height_in;
      end
   end

   always_ff @(posedge clock) begin
      turn_acc_ff <= turn_acc_in;
      start_x_ff  <= start_x_in;
      start_y_ff  <= start_y_in;
      out_xs_ff   <= out_xs_in;
      out_ys_ff   <= out_ys_in;
      out_xe_ff   <= out_xe_in;
      out_ye_ff   <= out_ye_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.x_start = out_xs_ff;
   assign rsp_chan.y_start = out_ys_ff;
   assign rsp_chan.x_end   = out_xe_ff;
   assign rsp_chan.y_end   = out_ye_ff;

   // The stored heading always lies within one full turn.
   assert property (@(posedge clock) disable iff (reset) heading_ff < HEADING_W'(FULL_TURN))
      else $error("heading outside one full turn");

   // The rotator only finishes while a forward command is waiting for it.
   assert property (@(posedge clock) disable iff (reset)
      cordic_rsp.done |-> state_ff == ST_ROTATE)
      else $error("rotator finished outside a forward command");

   // No rotation is in progress while commands are being taken.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !cordic_rsp.busy)
      else $error("rotator busy while the sequencer is idle");

   // A latched segment is presented in the next cycle and the sequencer is free again.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LATCH && (!rsp_valid_ff || rsp_chan.ready))
      |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("segment not presented after latching");

endmodule
